// ===== rtl/minimal_standard_random_range_core_assert.svh =====
// ============================================================================
// Assertion macros for the minimal standard random range core
// Concurrent assertion helpers that compile away when SYNTHESIS is defined.
// ============================================================================
`ifndef MINIMAL_STANDARD_RANDOM_RANGE_CORE_ASSERT_SVH
`define MINIMAL_STANDARD_RANDOM_RANGE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define MSRR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("msrr assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define MSRR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("msrr assertion failed");
`else
`define MSRR_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define MSRR_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/msrr_pkg.sv =====
// ============================================================================
// msrr_pkg
// Shared types and constants of the minimal standard random range core.
// ============================================================================
package msrr_pkg;

    // Generator constants.
    localparam logic [14:0] MULT    = 15'd16807;
    localparam logic [31:0] RNG_MAX = 32'h7FFF_FFFF;

    // Request command codes.
    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_RAW   = 2'd1,
        CMD_RANGE = 2'd2
    } t_cmd_code;

    // Source of the response value.
    typedef enum logic [2:0] {
        RES_SEED,
        RES_LOW,
        RES_ERR,
        RES_ZERO,
        RES_RANGE
    } t_res_sel;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     capture;
        logic     mul;
        logic     fold1;
        logic     fold2;
        logic     div_go_span;
        logic     div_go_seed;
        logic     res_load;
        t_res_sel res_sel;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic empty;
        logic too_big;
        logic div_done;
    } t_dp_stat;

endpackage

// ===== rtl/msrr_if.sv =====
// ============================================================================
// msrr request and response interfaces
// Valid/ready channels carrying the request and response payloads.
// ============================================================================
interface msrr_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         command;
    logic [31:0]        seed_value;
    logic signed [31:0] range_low;
    logic signed [31:0] range_high;

    modport source (output valid, command, seed_value, range_low, range_high,
                    input ready);
    modport sink   (input valid, command, seed_value, range_low, range_high,
                    output ready);
endinterface

interface msrr_out_if;
    logic               valid;
    logic               ready;
    logic signed [32:0] value;
    logic               range_error;

    modport source (output valid, value, range_error, input ready);
    modport sink   (input valid, value, range_error, output ready);
endinterface

// ===== rtl/msrr_div.sv =====
// ============================================================================
// msrr_div
// Restoring radix-2 unsigned divider, 32 by 32 bits, one quotient bit a cycle.
// ============================================================================
module msrr_div
    import msrr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_done,
    output logic [31:0] o_quotient
);

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [31:0] r_rem;
    logic [31:0] r_quo;
    logic [31:0] r_dvs;

    logic [33:0] w_diff;
    logic        w_ge;
    logic [31:0] n_rem;

    // Trial subtraction of the divisor from the shifted partial remainder.
    always_comb begin
        w_diff = {1'b0, r_rem, r_quo[31]} - {2'b00, r_dvs};
        w_ge   = !w_diff[33];
        n_rem  = w_ge ? w_diff[31:0] : {r_rem[30:0], r_quo[31]};
    end

    // Control: busy flag, bit counter and done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd31;
            end else if (r_busy) begin
                if (r_cnt == 5'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 5'd1;
                end
            end
        end
    end

    // Payload: remainder, quotient shift register and divisor.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[30:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== rtl/msrr_dp.sv =====
// ============================================================================
// msrr_dp
// Datapath: generator state, split 16-bit products with end-around folding,
// span check, shared divider and the response registers.
// ============================================================================
module msrr_dp
    import msrr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    input  logic [1:0]         i_command,
    input  logic [31:0]        i_seed_value,
    input  logic signed [31:0] i_range_low,
    input  logic signed [31:0] i_range_high,
    output t_dp_stat           o_stat,
    output logic signed [32:0] o_value,
    output logic               o_range_error
);

    logic [31:0]        r_seed;
    logic [30:0]        r_plo;
    logic [30:0]        r_phi;
    logic [31:0]        r_acc;
    logic signed [31:0] r_low;
    logic [31:0]        r_span;
    logic               r_empty;
    logic               r_big;
    logic signed [32:0] r_value;
    logic               r_err;

    logic [33:0] w_span;
    logic [31:0] w_sum1;
    logic [31:0] w_fold1;
    logic [31:0] w_sum2;
    logic [31:0] w_fold2;
    logic        w_div_go;
    logic [31:0] w_dividend;
    logic [31:0] w_divisor;
    logic        w_div_done;
    logic [31:0] w_quo;
    logic signed [32:0] n_value;

    // Exact span of a ranged request, high - low + 1.
    assign w_span = {{2{i_range_high[31]}}, i_range_high}
                  - {{2{i_range_low[31]}}, i_range_low} + 34'd1;

    // End-around folds of the partial products into 31 bits.
    always_comb begin
        w_sum1  = {1'b0, r_plo} + {1'b0, r_phi[14:0], 16'h0000};
        w_fold1 = w_sum1[31] ? ({1'b0, w_sum1[30:0]} + 32'd1) : w_sum1;
        w_sum2  = r_acc + {16'h0000, r_phi[30:15]};
        w_fold2 = w_sum2[31] ? ({1'b0, w_sum2[30:0]} + 32'd1) : w_sum2;
    end

    // Generator state; reset to zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= '0;
        end else if (i_cmd.capture && (i_command == CMD_LOAD)) begin
            r_seed <= i_seed_value;
        end else if (i_cmd.fold2) begin
            r_seed <= w_fold2;
        end
    end

    // Products, fold accumulator and captured range operands.
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_plo <= 31'({16'h0000, MULT} * {15'h0000, r_seed[15:0]});
            r_phi <= 31'({16'h0000, MULT} * {15'h0000, r_seed[31:16]});
        end
        if (i_cmd.fold1) begin
            r_acc <= w_fold1;
        end
        if (i_cmd.capture) begin
            r_low   <= i_range_low;
            r_span  <= w_span[31:0];
            r_empty <= (i_range_high <= i_range_low);
            r_big   <= (w_span[33:31] != 3'b000);
        end
    end

    // Shared divider: maximum over span first, then state over that quotient.
    assign w_div_go   = i_cmd.div_go_span || i_cmd.div_go_seed;
    assign w_dividend = i_cmd.div_go_span ? RNG_MAX : r_seed;
    assign w_divisor  = i_cmd.div_go_span ? r_span : w_quo;

    msrr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_go),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    // Response value selection.
    always_comb begin
        case (i_cmd.res_sel)
            RES_SEED:  n_value = {1'b0, r_seed};
            RES_LOW:   n_value = {r_low[31], r_low};
            RES_RANGE: n_value = {r_low[31], r_low} + {1'b0, w_quo};
            default:   n_value = '0;
        endcase
    end

    // Response registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_value <= n_value;
            r_err   <= (i_cmd.res_sel == RES_ERR);
        end
    end

    assign o_stat.empty    = r_empty;
    assign o_stat.too_big  = r_big;
    assign o_stat.div_done = w_div_done;
    assign o_value         = r_value;
    assign o_range_error   = r_err;

endmodule

// ===== rtl/msrr_ctrl.sv =====
// ============================================================================
// msrr_ctrl
// Controller: sequences advances, divisions and the response handshake.
// ============================================================================
module msrr_ctrl
    import msrr_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic [1:0] i_command,
    input  logic     i_out_ready,
    input  t_dp_stat i_stat,
    output logic     o_in_ready,
    output logic     o_out_valid,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_DIV1_GO,
        S_DIV1_WAIT,
        S_MUL,
        S_FOLD1,
        S_FOLD2,
        S_DIV2_GO,
        S_DIV2_WAIT,
        S_DONE
    } t_state;

    t_state   r_state, n_state;
    logic     r_adv_left, n_adv_left;
    logic     r_is_range, n_is_range;
    t_res_sel r_sel, n_sel;
    logic     r_out_valid, n_out_valid;

    // Next state and datapath commands.
    always_comb begin
        n_state     = r_state;
        n_adv_left  = r_adv_left;
        n_is_range  = r_is_range;
        n_sel       = r_sel;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_cmd.res_sel = r_sel;
        o_in_ready  = (r_state == S_IDLE);

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_is_range    = 1'b0;
                    n_adv_left    = 1'b0;
                    case (i_command)
                        CMD_LOAD: begin
                            n_adv_left = 1'b1;
                            n_state    = S_MUL;
                        end
                        CMD_RAW: begin
                            n_state = S_MUL;
                        end
                        CMD_RANGE: begin
                            n_is_range = 1'b1;
                            n_state    = S_CHECK;
                        end
                        default: begin
                            n_sel   = RES_ZERO;
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_CHECK: begin
                if (i_stat.empty) begin
                    n_sel   = RES_LOW;
                    n_state = S_DONE;
                end else if (i_stat.too_big) begin
                    n_sel   = RES_ERR;
                    n_state = S_DONE;
                end else begin
                    n_state = S_DIV1_GO;
                end
            end
            S_DIV1_GO: begin
                o_cmd.div_go_span = 1'b1;
                n_state           = S_DIV1_WAIT;
            end
            S_DIV1_WAIT: begin
                if (i_stat.div_done) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_FOLD1;
            end
            S_FOLD1: begin
                o_cmd.fold1 = 1'b1;
                n_state     = S_FOLD2;
            end
            S_FOLD2: begin
                o_cmd.fold2 = 1'b1;
                if (r_adv_left) begin
                    n_adv_left = 1'b0;
                    n_state    = S_MUL;
                end else if (r_is_range) begin
                    n_state = S_DIV2_GO;
                end else begin
                    n_sel   = RES_SEED;
                    n_state = S_DONE;
                end
            end
            S_DIV2_GO: begin
                o_cmd.div_go_seed = 1'b1;
                n_state           = S_DIV2_WAIT;
            end
            S_DIV2_WAIT: begin
                if (i_stat.div_done) begin
                    n_sel   = RES_RANGE;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.res_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_adv_left  <= 1'b0;
            r_is_range  <= 1'b0;
            r_sel       <= RES_ZERO;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_adv_left  <= n_adv_left;
            r_is_range  <= n_is_range;
            r_sel       <= n_sel;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== rtl/minimal_standard_random_range_core.sv =====
// ============================================================================
// minimal_standard_random_range_core
// Park-Miller minimal standard generator with seed load, raw and ranged draws.
// ============================================================================
//
//  Channel   Dir  Payload                                    Handshake
//  i_req     in   command, seed_value, range_low, range_high valid / ready
//  o_rsp     out  value, range_error                         valid / ready
//
// One request is in flight at a time. A raw draw runs the multiply and fold steps
// once and a seed load runs them twice before the response. A ranged draw makes
// two passes through the shared radix-2 divider; empty or oversized ranges
// answer without a division.
// Reset is synchronous and clears the generator state to zero.
// A new request is taken while a finished response still waits on o_rsp.
module minimal_standard_random_range_core
    import msrr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    msrr_in_if.sink     i_req,
    msrr_out_if.source  o_rsp
);

`include "minimal_standard_random_range_core_assert.svh"

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;
    logic     w_in_ready;
    logic     w_out_valid;

    // Sequencing of the request through the datapath.
    msrr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_command   (i_req.command),
        .i_out_ready (o_rsp.ready),
        .i_stat      (w_stat),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .o_cmd       (w_cmd)
    );

    // Arithmetic and storage.
    msrr_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_command     (i_req.command),
        .i_seed_value  (i_req.seed_value),
        .i_range_low   (i_req.range_low),
        .i_range_high  (i_req.range_high),
        .o_stat        (w_stat),
        .o_value       (o_rsp.value),
        .o_range_error (o_rsp.range_error)
    );

    assign i_req.ready = w_in_ready;
    assign o_rsp.valid = w_out_valid;

    // A flagged range error always carries a zero value.
    `MSRR_ASSERT_IMP(a_err_zero, i_clk, i_rst_n, o_rsp.valid && o_rsp.range_error, o_rsp.value == 33'sd0)
    // A response is never loaded over one that has not been taken.
    `MSRR_ASSERT_IMP(a_no_overwrite, i_clk, i_rst_n, w_cmd.res_load, !o_rsp.valid || o_rsp.ready)
    // After a request is accepted the block is busy the next cycle.
    `MSRR_ASSERT_NXT(a_busy_after, i_clk, i_rst_n, w_cmd.capture, !i_req.ready)
    // The span division starts only for a nonempty range that fits.
    `MSRR_ASSERT_IMP(a_span_ok, i_clk, i_rst_n, w_cmd.div_go_span, !w_stat.empty && !w_stat.too_big)

endmodule
